### design/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg
// Widths, constants and calendar helpers for the date difference unit.
// ----------------------------------------------------------------------------
package cdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ORD_W   = 2;
    localparam int ALU_W   = YEAR_W + MONTH_W + DAY_W;

    localparam logic [ORD_W-1:0] ORD_EQUAL = 2'd0;
    localparam logic [ORD_W-1:0] ORD_FIRST = 2'd1;
    localparam logic [ORD_W-1:0] ORD_LATER = 2'd2;

    localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] M_APR = 4'd4;
    localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] M_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

    localparam int LEAP_CYCLE = 400;
    localparam int CENTURY    = 100;
    localparam int MOD_STEPS  = 6;
    localparam int YEAR_MONTHS = 12;

    function automatic logic is_leap(input logic [8:0] rem);
        logic century;
        century = (rem == 9'(CENTURY)) || (rem == 9'(2 * CENTURY))
                || (rem == 9'(3 * CENTURY));
        return ((rem[1:0] == 2'b00) && !century) || (rem == 9'd0);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == M_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m == M_APR || m == M_JUN || m == M_SEP || m == M_NOV) begin
            len = 5'd30;
        end
        return len;
    endfunction

    function automatic logic date_ok(input logic [MONTH_W-1:0] m,
                                     input logic [DAY_W-1:0] d,
                                     input logic leap);
        return (m >= M_JAN) && (m <= M_DEC) && (d != '0) && (d <= month_len(m, leap));
    endfunction

    function automatic logic [MONTH_W-1:0] prev_month(input logic [MONTH_W-1:0] m);
        return (m == M_JAN) ? M_DEC : MONTH_W'(m - 1'b1);
    endfunction

endpackage

### design/cdd_alu.sv
// ----------------------------------------------------------------------------
// cdd_alu
// Shared add/subtract unit with carry out, reused on each arithmetic step of the sequencer.
// ----------------------------------------------------------------------------
module cdd_alu (
    input  logic [cdd_pkg::ALU_W-1:0] i_a,
    input  logic [cdd_pkg::ALU_W-1:0] i_b,
    input  logic                      i_sub,
    output logic [cdd_pkg::ALU_W-1:0] o_sum,
    output logic                      o_carry
);
    import cdd_pkg::*;

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   full;

    assign b_eff   = i_sub ? ~i_b : i_b;
    assign full    = {1'b0, i_a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, i_sub};
    assign o_sum   = full[ALU_W-1:0];
    assign o_carry = full[ALU_W];

endmodule

### design/calendar_date_difference_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_difference_unit
// Order and years/months/days distance of two Gregorian dates.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_ready carry one word of two dates. Output channel:
// o_valid/i_ready carry one word of order, span and validity flags.
// A small sequencer drives one shared add/subtract unit through its steps:
// twelve restoring subtract steps reduce both years modulo 400 for the leap
// rule, then one step each for the order compare and the year, month and day
// differences, up to two day borrows of two steps each, a month fix-up and a
// year fix-up, and one step to hand over the result.
// One word is taken per pass.
// o_ready is high only while the sequencer is idle. The output register
// holds a finished word while the receiver stalls, and the next word may be
// accepted meanwhile; its result waits until the held word is taken.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module calendar_date_difference_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cdd_pkg::YEAR_W-1:0]  i_first_year,
    input  logic [cdd_pkg::MONTH_W-1:0] i_first_month,
    input  logic [cdd_pkg::DAY_W-1:0]   i_first_day,
    input  logic [cdd_pkg::YEAR_W-1:0]  i_second_year,
    input  logic [cdd_pkg::MONTH_W-1:0] i_second_month,
    input  logic [cdd_pkg::DAY_W-1:0]   i_second_day,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cdd_pkg::ORD_W-1:0]   o_order,
    output logic [cdd_pkg::YEAR_W-1:0]  o_span_years,
    output logic [cdd_pkg::MONTH_W-1:0] o_span_months,
    output logic [cdd_pkg::DAY_W-1:0]   o_span_days,
    output logic                        o_first_valid,
    output logic                        o_second_valid
);
    import cdd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MOD  = 4'd1;
    localparam logic [3:0] S_ORD  = 4'd2;
    localparam logic [3:0] S_YRS  = 4'd3;
    localparam logic [3:0] S_MON  = 4'd4;
    localparam logic [3:0] S_DAY  = 4'd5;
    localparam logic [3:0] S_BRD  = 4'd6;
    localparam logic [3:0] S_BRM  = 4'd7;
    localparam logic [3:0] S_MFX  = 4'd8;
    localparam logic [3:0] S_YFX  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam logic [YEAR_W-1:0] LEAP_BASE = YEAR_W'(LEAP_CYCLE);

    logic [3:0]         r_state, n_state;
    logic [2:0]         r_cnt, n_cnt;
    logic               r_sel, n_sel;
    logic               r_brw, n_brw;
    logic [YEAR_W-1:0]  r_rem, n_rem;
    logic               r_leap_a, n_leap_a, r_leap_b, n_leap_b;
    logic [YEAR_W-1:0]  r_ay, n_ay, r_by, n_by;
    logic [MONTH_W-1:0] r_am, n_am, r_bm, n_bm, r_cm, n_cm;
    logic [DAY_W-1:0]   r_ad, n_ad, r_bd, n_bd;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [YEAR_W-1:0]  r_years, n_years;
    logic [5:0]         r_months, n_months;
    logic [6:0]         r_days, n_days;
    logic               r_fv, n_fv, r_sv, n_sv;

    logic               r_o_valid, n_o_valid;
    logic [ORD_W-1:0]   r_o_order, n_o_order;
    logic [YEAR_W-1:0]  r_o_years, n_o_years;
    logic [MONTH_W-1:0] r_o_months, n_o_months;
    logic [DAY_W-1:0]   r_o_days, n_o_days;
    logic               r_o_fv, n_o_fv, r_o_sv, n_o_sv;

    logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
    logic               alu_sub, alu_carry;
    logic [2:0]         shift;
    logic [MONTH_W-1:0] back_m;

    assign shift  = 3'(MOD_STEPS - 1) - r_cnt;
    assign back_m = prev_month(r_cm);

    cdd_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (r_state)
            S_MOD: begin
                alu_a = ALU_W'(r_rem);
                alu_b = ALU_W'(LEAP_BASE << shift);
            end
            S_ORD: begin
                alu_a = {r_ay, r_am, r_ad};
                alu_b = {r_by, r_bm, r_bd};
            end
            S_YRS: begin
                alu_a = ALU_W'(r_by);
                alu_b = ALU_W'(r_ay);
            end
            S_MON: begin
                alu_a = ALU_W'(r_bm);
                alu_b = ALU_W'(r_am);
            end
            S_DAY: begin
                alu_a = ALU_W'(r_bd);
                alu_b = ALU_W'(r_ad);
            end
            S_BRD: begin
                alu_a   = {{(ALU_W-7){r_days[6]}}, r_days};
                alu_b   = ALU_W'(month_len(back_m, r_leap_b));
                alu_sub = 1'b0;
            end
            S_BRM: begin
                alu_a = {{(ALU_W-6){r_months[5]}}, r_months};
                alu_b = ALU_W'(1);
            end
            S_MFX: begin
                alu_a   = {{(ALU_W-6){r_months[5]}}, r_months};
                alu_b   = ALU_W'(YEAR_MONTHS);
                alu_sub = 1'b0;
            end
            S_YFX: begin
                alu_a = ALU_W'(r_years);
                alu_b = ALU_W'(1);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sel      = r_sel;
        n_brw      = r_brw;
        n_rem      = r_rem;
        n_leap_a   = r_leap_a;
        n_leap_b   = r_leap_b;
        n_ay       = r_ay;
        n_am       = r_am;
        n_ad       = r_ad;
        n_by       = r_by;
        n_bm       = r_bm;
        n_bd       = r_bd;
        n_cm       = r_cm;
        n_ord      = r_ord;
        n_years    = r_years;
        n_months   = r_months;
        n_days     = r_days;
        n_fv       = r_fv;
        n_sv       = r_sv;
        n_o_valid  = r_o_valid;
        n_o_order  = r_o_order;
        n_o_years  = r_o_years;
        n_o_months = r_o_months;
        n_o_days   = r_o_days;
        n_o_fv     = r_o_fv;
        n_o_sv     = r_o_sv;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ay    = i_first_year;
                    n_am    = i_first_month;
                    n_ad    = i_first_day;
                    n_by    = i_second_year;
                    n_bm    = i_second_month;
                    n_bd    = i_second_day;
                    n_rem   = i_first_year;
                    n_cnt   = '0;
                    n_sel   = 1'b0;
                    n_brw   = 1'b0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (alu_carry) begin
                    n_rem = alu_sum[YEAR_W-1:0];
                end
                if (r_cnt == 3'(MOD_STEPS - 1)) begin
                    n_cnt = '0;
                    if (!r_sel) begin
                        n_leap_a = is_leap(n_rem[8:0]);
                        n_rem    = r_by;
                        n_sel    = 1'b1;
                    end else begin
                        n_leap_b = is_leap(n_rem[8:0]);
                        n_state  = S_ORD;
                    end
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_ORD: begin
                n_fv = date_ok(r_am, r_ad, r_leap_a);
                n_sv = date_ok(r_bm, r_bd, r_leap_b);
                if (alu_sum == '0) begin
                    n_ord    = ORD_EQUAL;
                    n_years  = '0;
                    n_months = '0;
                    n_days   = '0;
                    n_state  = S_DONE;
                end else if (!alu_carry) begin
                    n_ord   = ORD_FIRST;
                    n_cm    = r_bm;
                    n_state = S_YRS;
                end else begin
                    n_ord    = ORD_LATER;
                    n_ay     = r_by;
                    n_am     = r_bm;
                    n_ad     = r_bd;
                    n_by     = r_ay;
                    n_bm     = r_am;
                    n_bd     = r_ad;
                    n_cm     = r_am;
                    n_leap_a = r_leap_b;
                    n_leap_b = r_leap_a;
                    n_state  = S_YRS;
                end
            end
            S_YRS: begin
                n_years = alu_sum[YEAR_W-1:0];
                n_state = S_MON;
            end
            S_MON: begin
                n_months = alu_sum[5:0];
                n_state  = S_DAY;
            end
            S_DAY: begin
                n_days  = alu_sum[6:0];
                n_state = alu_sum[6] ? S_BRD : S_MFX;
            end
            S_BRD: begin
                n_days  = alu_sum[6:0];
                n_cm    = back_m;
                n_state = S_BRM;
            end
            S_BRM: begin
                n_months = alu_sum[5:0];
                if (!r_brw && r_days[6]) begin
                    n_brw   = 1'b1;
                    n_state = S_BRD;
                end else begin
                    n_state = S_MFX;
                end
            end
            S_MFX: begin
                if (r_months[5]) begin
                    n_months = alu_sum[5:0];
                    n_state  = S_YFX;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_YFX: begin
                n_years = alu_sum[YEAR_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_order  = r_ord;
                    n_o_years  = r_years;
                    n_o_months = r_months[MONTH_W-1:0];
                    n_o_days   = r_days[DAY_W-1:0];
                    n_o_fv     = r_fv;
                    n_o_sv     = r_sv;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_sel     <= 1'b0;
            r_brw     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cnt     <= n_cnt;
            r_sel     <= n_sel;
            r_brw     <= n_brw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_leap_a   <= n_leap_a;
        r_leap_b   <= n_leap_b;
        r_ay       <= n_ay;
        r_am       <= n_am;
        r_ad       <= n_ad;
        r_by       <= n_by;
        r_bm       <= n_bm;
        r_bd       <= n_bd;
        r_cm       <= n_cm;
        r_ord      <= n_ord;
        r_years    <= n_years;
        r_months   <= n_months;
        r_days     <= n_days;
        r_fv       <= n_fv;
        r_sv       <= n_sv;
        r_o_order  <= n_o_order;
        r_o_years  <= n_o_years;
        r_o_months <= n_o_months;
        r_o_days   <= n_o_days;
        r_o_fv     <= n_o_fv;
        r_o_sv     <= n_o_sv;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_order        = r_o_order;
    assign o_span_years   = r_o_years;
    assign o_span_months  = r_o_months;
    assign o_span_days    = r_o_days;
    assign o_first_valid  = r_o_fv;
    assign o_second_valid = r_o_sv;

endmodule

### sim/tb_calendar_date_difference_unit.sv
// ----------------------------------------------------------------------------
// tb_calendar_date_difference_unit
// Self-checking bench for the date difference unit. A short run of corner date
// pairs is followed by random pairs under several idle and back-pressure
// mixes. Each accepted pair is predicted, and each result is compared field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_calendar_date_difference_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cdd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASE_ITEMS   = 325;
    localparam int HOLDOFF_LEN   = 300;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
    } t_date_pair;

    typedef struct packed {
        logic [ORD_W-1:0]   order;
        logic [YEAR_W-1:0]  span_years;
        logic [MONTH_W-1:0] span_months;
        logic [DAY_W-1:0]   span_days;
        logic               first_valid;
        logic               second_valid;
    } t_date_span;

    class date_span_board;
        t_date_span expected_spans[$];
        int         mismatches;

        static function int month_days(int unsigned y, int unsigned m);
            bit leap;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m < M_JAN || m > M_DEC) return 31;
            if (m == M_FEB) return leap ? 29 : 28;
            if (m == M_APR || m == M_JUN || m == M_SEP || m == M_NOV) return 30;
            return 31;
        endfunction

        static function bit date_is_valid(int unsigned y, int unsigned m, int unsigned d);
            return (m >= M_JAN) && (m <= M_DEC) && (d >= 1) && (d <= month_days(y, m));
        endfunction

        function t_date_span predict_span(t_date_pair p);
            t_date_span  r;
            int unsigned ey, em, ed, ly, lm, ld, cy, cm;
            int          yrs, mos, dys;
            r   = '0;
            yrs = 0;
            mos = 0;
            dys = 0;
            if (p.first_year != p.second_year) begin
                r.order = (p.first_year < p.second_year) ? ORD_FIRST : ORD_LATER;
            end else if (p.first_month != p.second_month) begin
                r.order = (p.first_month < p.second_month) ? ORD_FIRST : ORD_LATER;
            end else if (p.first_day != p.second_day) begin
                r.order = (p.first_day < p.second_day) ? ORD_FIRST : ORD_LATER;
            end else begin
                r.order = ORD_EQUAL;
            end
            if (r.order != ORD_EQUAL) begin
                if (r.order == ORD_FIRST) begin
                    ey = p.first_year;  em = p.first_month;  ed = p.first_day;
                    ly = p.second_year; lm = p.second_month; ld = p.second_day;
                end else begin
                    ey = p.second_year; em = p.second_month; ed = p.second_day;
                    ly = p.first_year;  lm = p.first_month;  ld = p.first_day;
                end
                yrs = int'(ly) - int'(ey);
                mos = int'(lm) - int'(em);
                dys = int'(ld) - int'(ed);
                cy  = ly;
                cm  = lm;
                // borrow back from the later date, at most twice
                repeat (2) begin
                    if (dys < 0) begin
                        if (cm == M_JAN) begin
                            cm = M_DEC;
                            cy = cy - 1;
                        end else begin
                            cm = (cm - 1) & 15;
                        end
                        dys += month_days(cy, cm);
                        mos -= 1;
                    end
                end
                if (mos < 0) begin
                    mos += YEAR_MONTHS;
                    yrs -= 1;
                end
            end
            r.span_years   = yrs[YEAR_W-1:0];
            r.span_months  = mos[MONTH_W-1:0];
            r.span_days    = dys[DAY_W-1:0];
            r.first_valid  = date_is_valid(p.first_year, p.first_month, p.first_day);
            r.second_valid = date_is_valid(p.second_year, p.second_month, p.second_day);
            return r;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_pair(t_date_pair p);
            expected_spans.push_back(predict_span(p));
        endfunction

        task check_span(t_date_span got);
            t_date_span want;
            if (expected_spans.size() == 0) begin
                report_mismatch("result word with no date pair pending");
                return;
            end
            want = expected_spans.pop_front();
            if (got.order !== want.order)
                report_mismatch($sformatf("order got %0d want %0d", got.order, want.order));
            if (got.span_years !== want.span_years)
                report_mismatch($sformatf("span_years got %0d want %0d",
                                          got.span_years, want.span_years));
            if (got.span_months !== want.span_months)
                report_mismatch($sformatf("span_months got %0d want %0d",
                                          got.span_months, want.span_months));
            if (got.span_days !== want.span_days)
                report_mismatch($sformatf("span_days got %0d want %0d",
                                          got.span_days, want.span_days));
            if (got.first_valid !== want.first_valid)
                report_mismatch($sformatf("first_valid got %0b want %0b",
                                          got.first_valid, want.first_valid));
            if (got.second_valid !== want.second_valid)
                report_mismatch($sformatf("second_valid got %0b want %0b",
                                          got.second_valid, want.second_valid));
        endtask
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [YEAR_W-1:0]  i_first_year   = '0;
    logic [MONTH_W-1:0] i_first_month  = '0;
    logic [DAY_W-1:0]   i_first_day    = '0;
    logic [YEAR_W-1:0]  i_second_year  = '0;
    logic [MONTH_W-1:0] i_second_month = '0;
    logic [DAY_W-1:0]   i_second_day   = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [ORD_W-1:0]   o_order;
    logic [YEAR_W-1:0]  o_span_years;
    logic [MONTH_W-1:0] o_span_months;
    logic [DAY_W-1:0]   o_span_days;
    logic               o_first_valid;
    logic               o_second_valid;

    date_span_board board = new();

    int         send_idle_pct   = 0;
    int         recv_stall_pct  = 0;
    int         holdoff_request = 0;
    int         holdoff_left    = 0;
    int         quiet_cycles    = 0;
    t_date_pair seen_pair;
    t_date_span seen_span;

    calendar_date_difference_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first_year   (i_first_year),
        .i_first_month  (i_first_month),
        .i_first_day    (i_first_day),
        .i_second_year  (i_second_year),
        .i_second_month (i_second_month),
        .i_second_day   (i_second_day),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_order        (o_order),
        .o_span_years   (o_span_years),
        .o_span_months  (o_span_months),
        .o_span_days    (o_span_days),
        .o_first_valid  (o_first_valid),
        .o_second_valid (o_second_valid)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            seen_pair.first_year   = i_first_year;
            seen_pair.first_month  = i_first_month;
            seen_pair.first_day    = i_first_day;
            seen_pair.second_year  = i_second_year;
            seen_pair.second_month = i_second_month;
            seen_pair.second_day   = i_second_day;
            board.note_pair(seen_pair);
        end
        if (i_rst_n && o_valid && i_ready) begin
            seen_span.order        = o_order;
            seen_span.span_years   = o_span_years;
            seen_span.span_months  = o_span_months;
            seen_span.span_days    = o_span_days;
            seen_span.first_valid  = o_first_valid;
            seen_span.second_valid = o_second_valid;
            board.check_span(seen_span);
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (holdoff_request > 0) begin
                holdoff_left    = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0) begin
                i_ready <= 1'b0;
                holdoff_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_dates(int unsigned y1, int unsigned m1, int unsigned d1,
                              int unsigned y2, int unsigned m2, int unsigned d2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_first_year   <= y1[YEAR_W-1:0];
        i_first_month  <= m1[MONTH_W-1:0];
        i_first_day    <= d1[DAY_W-1:0];
        i_second_year  <= y2[YEAR_W-1:0];
        i_second_month <= m2[MONTH_W-1:0];
        i_second_day   <= d2[DAY_W-1:0];
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic int unsigned random_year();
        return ($urandom_range(3) == 0) ? 4 * $urandom_range(2499) : $urandom_range(9999);
    endfunction

    task automatic send_random_pair();
        int unsigned y1, m1, d1, y2, m2, d2, kind;
        int          near_year;
        kind = $urandom_range(99);
        y1   = random_year();
        m1   = $urandom_range(M_DEC, M_JAN);
        d1   = $urandom_range(date_span_board::month_days(y1, m1), 1);
        if (kind < 12) begin
            y2 = y1;
            m2 = m1;
            d2 = d1;
        end else if (kind < 85) begin
            if (kind < 55) begin
                near_year = int'(y1) + int'($urandom_range(4)) - 2;
                if (near_year < 0) near_year = 0;
                if (near_year > 9999) near_year = 9999;
                y2 = near_year;
            end else begin
                y2 = random_year();
            end
            m2 = $urandom_range(M_DEC, M_JAN);
            d2 = $urandom_range(date_span_board::month_days(y2, m2), 1);
        end else begin
            y1 = $urandom_range(9999);
            m1 = $urandom_range(15);
            d1 = $urandom_range(31);
            y2 = ($urandom_range(1) == 0) ? y1 : $urandom_range(9999);
            m2 = $urandom_range(15);
            d2 = $urandom_range(31);
        end
        send_dates(y1, m1, d1, y2, m2, d2);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.expected_spans.size() != 0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_dates(2000, 2, 29, 2000, 2, 29);
        send_dates(0, 0, 0, 0, 0, 0);
        send_dates(9999, 12, 31, 0, 1, 1);
        send_dates(0, 1, 1, 9999, 12, 31);
        send_dates(2024, 2, 29, 2023, 2, 28);
        send_dates(1900, 2, 29, 1900, 3, 1);
        send_dates(2100, 2, 29, 2000, 2, 29);
        send_dates(2023, 1, 31, 2023, 3, 1);
        send_dates(2024, 1, 31, 2024, 3, 1);
        send_dates(2022, 12, 31, 2023, 1, 30);
        send_dates(4, 3, 20, 5, 0, 3);
        send_dates(7, 15, 31, 7, 14, 0);
        send_dates(2023, 4, 31, 2023, 6, 0);
        send_dates(0, 0, 30, 0, 1, 2);
        send_dates(10, 12, 30, 11, 0, 0);
        send_dates(2023, 2, 31, 2023, 3, 0);
        send_dates(2020, 5, 10, 2020, 5, 3);
        send_dates(2020, 7, 1, 2020, 2, 1);
        send_dates(9999, 1, 1, 9998, 12, 31);
        send_dates(8191, 13, 16, 8191, 12, 15);
        send_dates(2400, 2, 29, 2399, 3, 29);
        send_dates(1, 1, 1, 0, 12, 31);
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 0 && n == PHASE_ITEMS / 2) holdoff_request = HOLDOFF_LEN;
                send_random_pair();
            end
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_spans.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
design/cdd_pkg.sv
design/cdd_alu.sv
design/calendar_date_difference_unit.sv
sim/tb_calendar_date_difference_unit.sv
